// ----- src/vna_pkg.sv -----
`timescale 1ns / 1ps
package vna_pkg;

  localparam int unsigned VerticesDefault = 1024;
  localparam int unsigned IdxW = 10;
  localparam int unsigned CoordW = 16;
  localparam int unsigned SumW = 48;
  localparam int unsigned NormW = 16;
  localparam logic [NormW-1:0] UnitQ14 = 16'd16384;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_WRITE = 2'd1,
    OP_TRI   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic [IdxW-1:0]         vertex_index;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [IdxW-1:0]         corner_a;
    logic [IdxW-1:0]         corner_b;
    logic [IdxW-1:0]         corner_c;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0]         read_index;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_TRI_RD,
    ST_TRI_LD,
    ST_TRI_CR1,
    ST_TRI_CR2,
    ST_ACC_RD,
    ST_ACC_WAIT,
    ST_ACC_WR,
    ST_RD_RD,
    ST_RD_WAIT,
    ST_NRM_SHIFT,
    ST_NRM_SQ,
    ST_NRM_SQRT,
    ST_NRM_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic latch_req;
    logic pos_write;
    logic pos_read;
    logic pos_load;
    logic cross1;
    logic cross2;
    logic acc_read;
    logic acc_write;
    logic corner_next;
    logic sum_read;
    logic sum_load;
    logic shift_step;
    logic square;
    logic sqrt_step;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic tri_ok;
    logic last_corner;
    logic shift_done;
    logic sqrt_done;
    logic div_done;
  } sts_t;

endpackage

// ----- src/vna_ctrl.sv -----
`timescale 1ns / 1ps
module vna_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_stall_o,
  input  vna_pkg::op_e     op_i,
  output logic             rsp_valid_o,
  input  logic             rsp_stall_i,
  input  vna_pkg::sts_t    sts_i,
  output vna_pkg::cmd_t    cmd_o
);
  import vna_pkg::*;

  state_e state_q, state_d;
  logic   acc;

  assign req_stall_o = (state_q != ST_IDLE);
  assign acc = req_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      rsp_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT) begin
        rsp_valid_o <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_o <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:       if (sts_i.clr_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (acc) begin
          case (op_i)
            OP_CLEAR: state_d = ST_CLR;
            OP_WRITE: state_d = ST_IDLE;
            OP_TRI:   state_d = ST_TRI_RD;
            default:  state_d = ST_RD_RD;
          endcase
        end
      end
      ST_TRI_RD: begin
        if (!sts_i.tri_ok) begin
          state_d = ST_IDLE;
        end else if (sts_i.last_corner) begin
          state_d = ST_TRI_LD;
        end
      end
      ST_TRI_LD:    state_d = ST_TRI_CR1;
      ST_TRI_CR1:   state_d = ST_TRI_CR2;
      ST_TRI_CR2:   state_d = ST_ACC_RD;
      ST_ACC_RD:    state_d = ST_ACC_WAIT;
      ST_ACC_WAIT:  state_d = ST_ACC_WR;
      ST_ACC_WR:    state_d = sts_i.last_corner ? ST_IDLE : ST_ACC_RD;
      ST_RD_RD:     state_d = ST_RD_WAIT;
      ST_RD_WAIT:   state_d = ST_NRM_SHIFT;
      ST_NRM_SHIFT: if (sts_i.shift_done) state_d = ST_NRM_SQ;
      ST_NRM_SQ:    state_d = ST_NRM_SQRT;
      ST_NRM_SQRT:  if (sts_i.sqrt_done) state_d = ST_NRM_DIV;
      ST_NRM_DIV:   if (sts_i.div_done) state_d = ST_OUT;
      ST_OUT:       if (!rsp_valid_o || !rsp_stall_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLR:   cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        cmd_o.latch_req = acc;
        cmd_o.clr_start = acc && (op_i == OP_CLEAR);
        cmd_o.pos_write = acc && (op_i == OP_WRITE);
        cmd_o.pos_read = acc && (op_i == OP_TRI);
      end
      ST_TRI_RD: begin
        cmd_o.pos_load = sts_i.tri_ok;
        cmd_o.corner_next = sts_i.tri_ok;
      end
      ST_TRI_LD:    cmd_o.cross1 = 1'b1;
      ST_TRI_CR1:   cmd_o.cross2 = 1'b1;
      ST_ACC_RD:    cmd_o.acc_read = 1'b1;
      ST_ACC_WR: begin
        cmd_o.acc_write = 1'b1;
        cmd_o.corner_next = 1'b1;
      end
      ST_RD_RD:     cmd_o.sum_read = 1'b1;
      ST_RD_WAIT:   cmd_o.sum_load = 1'b1;
      ST_NRM_SHIFT: cmd_o.shift_step = 1'b1;
      ST_NRM_SQ:    cmd_o.square = 1'b1;
      ST_NRM_SQRT:  cmd_o.sqrt_step = 1'b1;
      ST_NRM_DIV:   cmd_o.div_step = 1'b1;
      ST_OUT:       cmd_o.out_load = !rsp_valid_o || !rsp_stall_i;
      default:      cmd_o = '0;
    endcase
  end

endmodule

// ----- src/vna_dp.sv -----
`timescale 1ns / 1ps
module vna_dp #(
  parameter int unsigned Vertices = vna_pkg::VerticesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vna_pkg::req_t req_i,
  input  vna_pkg::cmd_t cmd_i,
  output vna_pkg::sts_t sts_o,
  output vna_pkg::rsp_t rsp_o
);
  import vna_pkg::*;

  localparam int unsigned AW = (Vertices > 1) ? $clog2(Vertices) : 1;
  localparam int unsigned CW = $clog2(Vertices + 1);
  localparam logic [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  logic [3*CoordW-1:0] pos_mem [Vertices];
  logic [3*SumW-1:0]   sum_mem [Vertices];

  req_t req_q;
  logic [CW-1:0] clr_q;
  logic [3*CoordW-1:0] pa_q, pb_q, pc_q;
  logic [AW-1:0] pra_q, prb_q, prc_q;
  logic signed [CoordW:0] ux_q, uy_q, uz_q, wx_q, wy_q, wz_q;
  logic signed [2*CoordW+1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [2*CoordW+2:0] nx_q, ny_q, nz_q;
  logic [1:0] corner_q;
  logic [AW-1:0] acc_addr_q;
  logic [3*SumW-1:0] acc_rd_q;

  logic [SumW-1:0] mx_q, my_q, mz_q;
  logic nsx_q, nsy_q, nsz_q;
  logic [63:0] rem_q, res_q, bit_q;
  logic [63:0] len_q;
  logic [1:0] dcomp_q;
  logic [4:0] dstep_q;
  logic [NormW:0] quo_q;
  logic [63:0] drem_q;
  logic [NormW-1:0] ox_q, oy_q, oz_q;
  logic zero_q;

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                               input logic signed [2*CoordW+2:0] n);
    logic signed [SumW:0] r;
    r = $signed({a[SumW-1], a}) + $signed({{(SumW-2*CoordW-2){n[2*CoordW+2]}}, n});
    if (r > $signed({1'b0, SumMax})) sat_add = SumMax;
    else if (r < $signed({1'b1, SumMin})) sat_add = SumMin;
    else sat_add = r[SumW-1:0];
  endfunction

  logic a_ok, b_ok, c_ok, v_ok;
  assign a_ok = 32'(req_i.corner_a) < Vertices;
  assign b_ok = 32'(req_i.corner_b) < Vertices;
  assign c_ok = 32'(req_i.corner_c) < Vertices;
  assign v_ok = 32'(req_q.vertex_index) < Vertices;

  logic [AW-1:0] wr_idx;
  assign wr_idx = AW'(req_i.vertex_index);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_write && 32'(req_i.vertex_index) < Vertices) begin
      pos_mem[wr_idx] <= {req_i.coord_x, req_i.coord_y, req_i.coord_z};
    end
  end

  logic [AW-1:0] corner_addr;
  always_comb begin
    case (corner_q)
      2'd0:    corner_addr = pra_q;
      2'd1:    corner_addr = prb_q;
      default: corner_addr = prc_q;
    endcase
  end

  // one position read per cycle, corners in turn
  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_read) begin
      pra_q <= AW'(req_i.corner_a);
      prb_q <= AW'(req_i.corner_b);
      prc_q <= AW'(req_i.corner_c);
    end
    if (cmd_i.pos_load) begin
      case (corner_q)
        2'd0:    pa_q <= pos_mem[corner_addr];
        2'd1:    pb_q <= pos_mem[corner_addr];
        default: pc_q <= pos_mem[corner_addr];
      endcase
    end
  end

  logic tri_ok_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_ok_q <= 1'b0;
    end else if (cmd_i.pos_read) begin
      tri_ok_q <= a_ok && b_ok && c_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) req_q <= req_i;
    if (cmd_i.cross1) begin
      ux_q <= {pb_q[47], pb_q[47:32]} - {pa_q[47], pa_q[47:32]};
      uy_q <= {pb_q[31], pb_q[31:16]} - {pa_q[31], pa_q[31:16]};
      uz_q <= {pb_q[15], pb_q[15:0]} - {pa_q[15], pa_q[15:0]};
      wx_q <= {pc_q[47], pc_q[47:32]} - {pa_q[47], pa_q[47:32]};
      wy_q <= {pc_q[31], pc_q[31:16]} - {pa_q[31], pa_q[31:16]};
      wz_q <= {pc_q[15], pc_q[15:0]} - {pa_q[15], pa_q[15:0]};
    end
    if (cmd_i.cross2) begin
      p0_q <= uy_q * wz_q;
      p1_q <= uz_q * wy_q;
      p2_q <= uz_q * wx_q;
      p3_q <= ux_q * wz_q;
      p4_q <= ux_q * wy_q;
      p5_q <= uy_q * wx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_read) begin
      nx_q <= {p0_q[2*CoordW+1], p0_q} - {p1_q[2*CoordW+1], p1_q};
      ny_q <= {p2_q[2*CoordW+1], p2_q} - {p3_q[2*CoordW+1], p3_q};
      nz_q <= {p4_q[2*CoordW+1], p4_q} - {p5_q[2*CoordW+1], p5_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= 2'd0;
    end else if (cmd_i.pos_read) begin
      corner_q <= 2'd0;
    end else if (cmd_i.corner_next) begin
      corner_q <= (corner_q == 2'd2) ? 2'd0 : corner_q + 2'd1;
    end
  end

  logic [AW-1:0] sum_rd_addr;
  assign sum_rd_addr = cmd_i.sum_read ? AW'(req_q.vertex_index) : corner_addr;

  // single-port sum store: cleared by a sweep, read then written per corner
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && clr_q < CW'(Vertices)) begin
      sum_mem[clr_q[AW-1:0]] <= '0;
    end else if (cmd_i.acc_write) begin
      sum_mem[acc_addr_q] <= {sat_add(acc_rd_q[3*SumW-1:2*SumW], nx_q),
                              sat_add(acc_rd_q[2*SumW-1:SumW], ny_q),
                              sat_add(acc_rd_q[SumW-1:0], nz_q)};
    end
    if (cmd_i.acc_read || cmd_i.sum_read) begin
      acc_rd_q <= sum_mem[sum_rd_addr];
      acc_addr_q <= sum_rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step && clr_q < CW'(Vertices)) begin
      clr_q <= clr_q + CW'(1);
    end
  end

  logic [SumW-1:0] sx, sy, sz, ax, ay, az;
  assign sx = acc_rd_q[3*SumW-1:2*SumW];
  assign sy = acc_rd_q[2*SumW-1:SumW];
  assign sz = acc_rd_q[SumW-1:0];
  assign ax = sx[SumW-1] ? -sx : sx;
  assign ay = sy[SumW-1] ? -sy : sy;
  assign az = sz[SumW-1] ? -sz : sz;

  logic shift_down, shift_up;
  assign shift_down = (mx_q >= SumW'(1) << 30) || (my_q >= SumW'(1) << 30) ||
                      (mz_q >= SumW'(1) << 30);
  assign shift_up = (mx_q < SumW'(1) << 29) && (my_q < SumW'(1) << 29) &&
                    (mz_q < SumW'(1) << 29);

  logic [63:0] trial;
  assign trial = res_q + bit_q;

  logic [SumW-1:0] dmag;
  always_comb begin
    case (dcomp_q)
      2'd0:    dmag = mx_q;
      2'd1:    dmag = my_q;
      default: dmag = mz_q;
    endcase
  end

  logic [63:0] dnum, dshift;
  assign dnum = (64'(dmag) << 14) + (len_q >> 1);
  assign dshift = (dstep_q == '0) ? (dnum >> NormW) :
                  ({drem_q[62:0], 1'b0} | 64'(dnum[6'(NormW - 32'(dstep_q))]));

  logic dtake;
  assign dtake = (dshift >= len_q);

  logic [NormW:0] quo_nx;
  assign quo_nx = {quo_q[NormW-1:0], dtake};

  logic [NormW-1:0] qsat;
  assign qsat = (quo_nx > {1'b0, UnitQ14}) ? UnitQ14 : quo_nx[NormW-1:0];

  logic dsign;
  always_comb begin
    case (dcomp_q)
      2'd0:    dsign = nsx_q;
      2'd1:    dsign = nsy_q;
      default: dsign = nsz_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_load) begin
      mx_q <= v_ok ? ax : '0;
      my_q <= v_ok ? ay : '0;
      mz_q <= v_ok ? az : '0;
      nsx_q <= sx[SumW-1];
      nsy_q <= sy[SumW-1];
      nsz_q <= sz[SumW-1];
      zero_q <= !v_ok || (sx == '0 && sy == '0 && sz == '0);
    end
    if (cmd_i.shift_step && !zero_q) begin
      if (shift_down) begin
        mx_q <= mx_q >> 1;
        my_q <= my_q >> 1;
        mz_q <= mz_q >> 1;
      end else if (shift_up) begin
        mx_q <= mx_q << 1;
        my_q <= my_q << 1;
        mz_q <= mz_q << 1;
      end
    end
    if (cmd_i.sqrt_step && bit_q == '0) begin
      len_q <= res_q;
    end
    if (cmd_i.div_step && dstep_q == 5'(NormW)) begin
      case (dcomp_q)
        2'd0:    ox_q <= dsign ? -qsat : qsat;
        2'd1:    oy_q <= dsign ? -qsat : qsat;
        default: oz_q <= dsign ? -qsat : qsat;
      endcase
    end
  end

  // square: three products summed combinationally, loaded as the sqrt seed
  logic [63:0] sq_sum;
  assign sq_sum = 64'(mx_q[29:0] * mx_q[29:0]) + 64'(my_q[29:0] * my_q[29:0])
                + 64'(mz_q[29:0] * mz_q[29:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
      res_q <= '0;
      rem_q <= '0;
      dstep_q <= '0;
      dcomp_q <= '0;
      drem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.square) begin
      rem_q <= sq_sum;
      res_q <= '0;
      bit_q <= 64'(1) << 62;
      dstep_q <= '0;
      dcomp_q <= '0;
      drem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.sqrt_step && bit_q != '0) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end else if (cmd_i.div_step) begin
      if (dstep_q == 5'(NormW)) begin
        dstep_q <= '0;
        drem_q <= '0;
        quo_q <= '0;
        dcomp_q <= (dcomp_q == 2'd2) ? 2'd0 : dcomp_q + 2'd1;
      end else begin
        dstep_q <= dstep_q + 5'd1;
        drem_q <= dtake ? dshift - len_q : dshift;
        quo_q <= quo_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_o.read_index <= req_q.vertex_index;
      rsp_o.normal_x <= zero_q ? '0 : ox_q;
      rsp_o.normal_y <= zero_q ? '0 : oy_q;
      rsp_o.normal_z <= zero_q ? UnitQ14 : oz_q;
    end
  end

  assign sts_o.clr_done = (clr_q == CW'(Vertices));
  assign sts_o.tri_ok = tri_ok_q;
  assign sts_o.last_corner = (corner_q == 2'd2);
  assign sts_o.shift_done = zero_q || (!shift_down && !shift_up);
  assign sts_o.sqrt_done = zero_q || (bit_q == '0);
  assign sts_o.div_done = zero_q || (dstep_q == 5'(NormW) && dcomp_q == 2'd2);

endmodule

// ----- src/vertex_normal_accumulator.sv -----
`timescale 1ns / 1ps
// Area-weighted vertex normal accumulator.
// Request channel: req_valid_i / req_stall_o carrying req_i (vna_pkg::req_t).
// Response channel: rsp_valid_o / rsp_stall_i carrying rsp_o (vna_pkg::rsp_t).
// One request is worked at a time; req_stall_o is high while it is busy.
// Add triangle: three position reads, cross product and three
// read-modify-writes of the single-port sum memory; a corner out of range
// ends it with no update. Read normal: the normalizing shift loop (up to 29
// steps), the bit-serial square root and three 17-step serial divides lead
// to rsp_valid_o; for a zero sum each of them finishes at once. Clear
// sweeps the sum memory one vertex at a time. After reset the same clearing
// pass holds req_stall_o high. Vertex positions are undefined until written.
// The response register holds its value while rsp_stall_i is high; a read
// that finishes meanwhile waits in its last step with req_stall_o high.
// Only read requests produce a response.
module vertex_normal_accumulator #(
  parameter int unsigned VERTICES = vna_pkg::VerticesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  vna_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output vna_pkg::rsp_t rsp_o
);
  import vna_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vna_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i,
    .req_stall_o,
    .op_i(op_e'(req_i.operation)),
    .rsp_valid_o,
    .rsp_stall_i,
    .sts_i(sts),
    .cmd_o(cmd)
  );

  vna_dp #(.Vertices(VERTICES)) u_dp (
    .clk_i,
    .rst_ni,
    .req_i,
    .cmd_i(cmd),
    .sts_o(sts),
    .rsp_o
  );

endmodule

// ----- src/vna_checker.sv -----
`timescale 1ns / 1ps
module vna_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_stall_o,
  input vna_pkg::req_t req_i,
  input logic          rsp_valid_o,
  input logic          rsp_stall_i,
  input vna_pkg::rsp_t rsp_o
);
  import vna_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response dropped under stall");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o && req_i.operation == OP_READ |=> req_stall_o)
    else $error("read not held busy");

  a_zero_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.normal_z <= $signed(UnitQ14)
      && rsp_o.normal_z >= -$signed(UnitQ14))
    else $error("normal out of range");

  a_busy_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> req_stall_o)
    else $error("clear pass skipped");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);

// ----- tb/tb_vertex_normal_accumulator.sv -----
`timescale 1ns / 1ps
module tb_vertex_normal_accumulator;
  import vna_pkg::*;

  localparam int unsigned NumVerts = VerticesDefault;
  localparam longint SumMax = 64'sd140737488355327;
  localparam longint SumMin = -SumMax - 1;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldOffCycles = 400;

  class mesh_normal_model;
    shortint pos_x[NumVerts];
    shortint pos_y[NumVerts];
    shortint pos_z[NumVerts];
    longint acc_x[NumVerts];
    longint acc_y[NumVerts];
    longint acc_z[NumVerts];
    rsp_t pending_normals[$];
    int unsigned errors;

    function new();
      errors = 0;
      clear_sums();
      foreach (pos_x[i]) begin
        pos_x[i] = 0;
        pos_y[i] = 0;
        pos_z[i] = 0;
      end
    endfunction

    function void clear_sums();
      foreach (acc_x[i]) begin
        acc_x[i] = 0;
        acc_y[i] = 0;
        acc_z[i] = 0;
      end
    endfunction

    function longint sat_add(longint a, longint n);
      longint r;
      r = a + n;
      if (r > SumMax) return SumMax;
      if (r < SumMin) return SumMin;
      return r;
    endfunction

    function longint unsigned int_sqrt(longint unsigned q);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > q) b = b >> 2;
      while (b != 0) begin
        if (q >= res + b) begin
          q = q - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function rsp_t unit_normal(logic [IdxW-1:0] idx);
      longint s[3];
      longint unsigned mag[3];
      longint unsigned m, q, len, r;
      bit neg[3];
      logic [NormW-1:0] comp[3];
      rsp_t o;
      s[0] = acc_x[idx];
      s[1] = acc_y[idx];
      s[2] = acc_z[idx];
      m = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = s[i] < 0;
        mag[i] = neg[i] ? -s[i] : s[i];
        if (mag[i] > m) m = mag[i];
      end
      o.read_index = idx;
      if (m == 0) begin
        o.normal_x = '0;
        o.normal_y = '0;
        o.normal_z = UnitQ14;
        return o;
      end
      while (m >= (64'd1 << 30)) begin
        m = m >> 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (m < (64'd1 << 29)) begin
        m = m << 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      q = 0;
      for (int i = 0; i < 3; i++) q = q + mag[i] * mag[i];
      len = int_sqrt(q);
      for (int i = 0; i < 3; i++) begin
        r = (mag[i] * 16384 + len / 2) / len;
        if (r > 16384) r = 16384;
        comp[i] = neg[i] ? -r[NormW-1:0] : r[NormW-1:0];
      end
      o.normal_x = comp[0];
      o.normal_y = comp[1];
      o.normal_z = comp[2];
      return o;
    endfunction

    function void note_request(req_t r);
      longint ux, uy, uz, wx, wy, wz, nx, ny, nz;
      logic [IdxW-1:0] c[3];
      case (op_e'(r.operation))
        OP_CLEAR: clear_sums();
        OP_WRITE: begin
          pos_x[r.vertex_index] = r.coord_x;
          pos_y[r.vertex_index] = r.coord_y;
          pos_z[r.vertex_index] = r.coord_z;
        end
        OP_TRI: begin
          c[0] = r.corner_a;
          c[1] = r.corner_b;
          c[2] = r.corner_c;
          ux = longint'(pos_x[c[1]]) - pos_x[c[0]];
          uy = longint'(pos_y[c[1]]) - pos_y[c[0]];
          uz = longint'(pos_z[c[1]]) - pos_z[c[0]];
          wx = longint'(pos_x[c[2]]) - pos_x[c[0]];
          wy = longint'(pos_y[c[2]]) - pos_y[c[0]];
          wz = longint'(pos_z[c[2]]) - pos_z[c[0]];
          nx = uy * wz - uz * wy;
          ny = uz * wx - ux * wz;
          nz = ux * wy - uy * wx;
          for (int k = 0; k < 3; k++) begin
            acc_x[c[k]] = sat_add(acc_x[c[k]], nx);
            acc_y[c[k]] = sat_add(acc_y[c[k]], ny);
            acc_z[c[k]] = sat_add(acc_z[c[k]], nz);
          end
        end
        default: pending_normals.push_back(unit_normal(r.vertex_index));
      endcase
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected response %h", $time, got);
        errors++;
        return;
      end
      want = pending_normals.pop_front();
      if (got.read_index !== want.read_index) begin
        $display("%0t: read_index expected %0d actual %0d", $time,
                 want.read_index, got.read_index);
        errors++;
      end
      if (got.normal_x !== want.normal_x) begin
        $display("%0t: normal_x expected %0d actual %0d", $time,
                 want.normal_x, got.normal_x);
        errors++;
      end
      if (got.normal_y !== want.normal_y) begin
        $display("%0t: normal_y expected %0d actual %0d", $time,
                 want.normal_y, got.normal_y);
        errors++;
      end
      if (got.normal_z !== want.normal_z) begin
        $display("%0t: normal_z expected %0d actual %0d", $time,
                 want.normal_z, got.normal_z);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic req_valid_i;
  logic req_stall_o;
  req_t req_i;
  logic rsp_valid_o;
  logic rsp_stall_i;
  rsp_t rsp_o;

  mesh_normal_model model;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit hold_off_pending;
  bit written[NumVerts];
  logic [IdxW-1:0] written_list[$];
  int unsigned quiet_cycles;

  vertex_normal_accumulator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(negedge clk_i) begin
    if (hold_off_pending) begin
      rsp_stall_i <= 1'b1;
      repeat (HoldOffCycles) @(negedge clk_i);
      hold_off_pending = 1'b0;
    end else begin
      rsp_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) model.check_response(rsp_o);
    if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("tb_vertex_normal_accumulator NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (req_stall_o);
    model.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic issue(input op_e op, input logic [IdxW-1:0] idx,
                       input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                       input logic [CoordW-1:0] z, input logic [IdxW-1:0] a,
                       input logic [IdxW-1:0] b, input logic [IdxW-1:0] c);
    req_t r;
    r.operation = op;
    r.vertex_index = idx;
    r.coord_x = x;
    r.coord_y = y;
    r.coord_z = z;
    r.corner_a = a;
    r.corner_b = b;
    r.corner_c = c;
    if (op == OP_WRITE && !written[idx]) begin
      written[idx] = 1'b1;
      written_list.push_back(idx);
    end
    send_request(r);
  endtask

  task automatic random_request();
    int unsigned pick;
    logic [IdxW-1:0] a, b, c, vi, ra, rb, rc;
    logic [CoordW-1:0] x, y, z;
    pick = $urandom_range(99);
    a = written_list[$urandom_range(written_list.size() - 1)];
    b = written_list[$urandom_range(written_list.size() - 1)];
    c = written_list[$urandom_range(written_list.size() - 1)];
    vi = IdxW'($urandom);
    ra = IdxW'($urandom);
    rb = IdxW'($urandom);
    rc = IdxW'($urandom);
    x = CoordW'($urandom);
    y = CoordW'($urandom);
    z = CoordW'($urandom);
    if (pick < 3) begin
      issue(OP_CLEAR, vi, x, y, z, ra, rb, rc);
    end else if (pick < 25) begin
      issue(OP_WRITE, vi, x, y, z, ra, rb, rc);
    end else if (pick < 65) begin
      issue(OP_TRI, vi, x, y, z, a, b, c);
    end else if (pick < 85) begin
      issue(OP_READ, a, x, y, z, ra, rb, rc);
    end else begin
      issue(OP_READ, vi, x, y, z, ra, rb, rc);
    end
  endtask

  initial begin
    model = new();
    send_idle_pct = 19;
    recv_stall_pct = 78;
    hold_off_pending = 1'b0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    rsp_stall_i = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    issue(OP_READ, 10'd0, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 10'd1023, 0, 0, 0, 0, 0, 0);
    issue(OP_WRITE, 10'd0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
    issue(OP_WRITE, 10'd1023, 16'h7fff, 16'h0000, 16'h0000, 0, 0, 0);
    issue(OP_WRITE, 10'd512, 16'h0000, 16'h7fff, 16'h0000, 0, 0, 0);
    issue(OP_WRITE, 10'd511, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0);
    issue(OP_WRITE, 10'd341, 16'hffff, 16'h0100, 16'h7fff, 0, 0, 0);
    issue(OP_TRI, 0, 0, 0, 0, 10'd0, 10'd1023, 10'd512);
    issue(OP_TRI, 0, 0, 0, 0, 10'd0, 10'd512, 10'd1023);
    issue(OP_TRI, 0, 0, 0, 0, 10'd511, 10'd341, 10'd1023);
    issue(OP_TRI, 0, 0, 0, 0, 10'd341, 10'd341, 10'd0);
    issue(OP_TRI, 0, 0, 0, 0, 10'd512, 10'd512, 10'd512);
    issue(OP_READ, 10'd0, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 10'd1023, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 10'd512, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 10'd511, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 10'd341, 0, 0, 0, 0, 0, 0);
    issue(OP_CLEAR, 10'h3ff, 16'hffff, 16'hffff, 16'hffff, 10'h3ff, 10'h3ff,
          10'h3ff);
    issue(OP_READ, 10'd1023, 0, 0, 0, 0, 0, 0);
    issue(OP_TRI, 0, 0, 0, 0, 10'd1023, 10'd0, 10'd512);
    issue(OP_READ, 10'd0, 0, 0, 0, 0, 0, 0);

    repeat (300) random_request();
    send_idle_pct = 78;
    recv_stall_pct = 19;
    repeat (300) random_request();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_pending = 1'b1;
    repeat (300) random_request();

    issue(OP_WRITE, 10'd1020, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0);
    issue(OP_WRITE, 10'd1021, 16'h7fff, 16'h7fff, 16'h8000, 0, 0, 0);
    issue(OP_WRITE, 10'd1022, 16'h7fff, 16'h8000, 16'h7fff, 0, 0, 0);
    repeat (40) issue(OP_TRI, 0, 0, 0, 0, 10'd1020, 10'd1021, 10'd1022);
    issue(OP_READ, 10'd1020, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 10'd1021, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 10'd1022, 0, 0, 0, 0, 0, 0);
    req_valid_i <= 1'b0;

    while (model.pending_normals.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (model.errors == 0) begin
      $display("tb_vertex_normal_accumulator OK");
    end else begin
      $display("tb_vertex_normal_accumulator NOT OK");
    end
    $finish;
  end

endmodule
